// ===== rtl/polyline_heading_curvature_defines.svh =====
// Assertion macros used by polyline_heading_curvature.sv.
`ifndef POLYLINE_HEADING_CURVATURE_DEFINES_SVH
`define POLYLINE_HEADING_CURVATURE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define PHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phc_pkg.sv =====
`default_nettype none
package phc_pkg;

  localparam int HALF_PI_Q    = 12868;
  localparam int PI_Q         = 25736;
  localparam int TWO_PI_Q     = 51472;
  localparam int CORDIC_STEPS = 14;

  typedef struct packed {
    logic signed [31:0] curvature;
    logic               invalid;
  } curv_res_t;

  function automatic logic signed [16:0] atan_q(input logic [3:0] i);
    logic signed [16:0] a;
    case (i)
      4'd0:    a = 17'sd6434;
      4'd1:    a = 17'sd3798;
      4'd2:    a = 17'sd2007;
      4'd3:    a = 17'sd1019;
      4'd4:    a = 17'sd511;
      4'd5:    a = 17'sd256;
      4'd6:    a = 17'sd128;
      4'd7:    a = 17'sd64;
      4'd8:    a = 17'sd32;
      4'd9:    a = 17'sd16;
      4'd10:   a = 17'sd8;
      4'd11:   a = 17'sd4;
      4'd12:   a = 17'sd2;
      4'd13:   a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

  // Brings an angle difference into (-pi, pi]; one step always suffices here.
  function automatic logic signed [15:0] wrap_q(input logic signed [17:0] d);
    logic signed [17:0] r;
    if (d > 18'(PI_Q)) begin
      r = d - 18'(TWO_PI_Q);
    end else if (d <= -18'(PI_Q)) begin
      r = d + 18'(TWO_PI_Q);
    end else begin
      r = d;
    end
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/polyline_heading_curvature.sv =====
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata: center_x, center_y; tlast: last_point
// m_axis    out        tdata: heading, curvature; tuser: invalid; tlast: last_result
// cfg       in         cfg_index selects start_heading (0) or end_heading (1)
// An inner point keeps the block busy while it is taken in (S_IDLE, S_FIRST), through 14
// CORDIC iterations, a launch (S_C1), the curvature unit (two squarings on one multiplier,
// 32 square-root steps, 31 division steps, a result step) and the loading of the output.
// A last point runs the curvature unit twice; a first point needs no CORDIC or curvature
// work, and a zero or very long span skips the curvature unit's squaring, root and division
// steps. Reset is synchronous and leaves the block ready with an empty run. A stalled result
// waits in the output register and stops the sequencer.
`include "polyline_heading_curvature_defines.svh"
module polyline_heading_curvature
  import phc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // center_x, center_y
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // heading, curvature
  output logic             m_tuser,  // invalid
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_CORD, S_C1, S_CURV1, S_EMIT1, S_C2, S_CURV2
  } state_t;

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_ONE  = 2'd1;
  localparam logic [1:0] PS_MORE = 2'd2;
  localparam logic       REG_START = 1'b0;

  state_t             state;
  logic signed [15:0] start_heading;
  logic signed [15:0] end_heading;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic               lastp;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] older_x;
  logic signed [31:0] older_y;
  logic signed [15:0] older_heading;
  logic [1:0]         points_seen;
  logic signed [15:0] h;
  logic               emit2;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] ox;
  logic signed [32:0] oy;
  logic               cord_start;
  logic               cord_done;
  logic signed [15:0] cord_heading;
  logic               curv_start;
  logic               curv_done;
  curv_res_t          curv_res;
  logic signed [15:0] base;
  logic signed [15:0] dh;
  logic signed [32:0] span_x;
  logic signed [32:0] span_y;
  logic               out_free;
  logic               emit_now;

  assign dx = {px[31], px} - {prev_x[31], prev_x};
  assign dy = {py[31], py} - {prev_y[31], prev_y};
  assign ox = {px[31], px} - {older_x[31], older_x};
  assign oy = {py[31], py} - {older_y[31], older_y};

  assign base       = (points_seen == PS_ONE) ? start_heading : older_heading;
  assign cord_start = (state == S_FIRST) && (points_seen != PS_NONE);
  assign curv_start = (state == S_C1) || (state == S_C2);
  assign out_free   = !m_tvalid || m_tready;
  assign emit_now   = out_free &&
                      (((state == S_FIRST) && (points_seen == PS_NONE) && lastp) ||
                       (state == S_EMIT1));
  assign s_tready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;

  always_comb begin
    if (state == S_C2) begin
      dh     = wrap_q({{2{end_heading[15]}}, end_heading} - {{2{h[15]}}, h});
      span_x = dx;
      span_y = dy;
    end else begin
      dh     = wrap_q({{2{h[15]}}, h} - {{2{base[15]}}, base});
      span_x = (points_seen == PS_ONE) ? dx : ox;
      span_y = (points_seen == PS_ONE) ? dy : oy;
    end
  end

  phc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .dx      (dx),
    .dy      (dy),
    .done    (cord_done),
    .heading (cord_heading)
  );

  phc_curv u_curv (
    .clk   (clk),
    .rst   (rst),
    .start (curv_start),
    .dh    (dh),
    .dx    (span_x),
    .dy    (span_y),
    .done  (curv_done),
    .res   (curv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      start_heading <= '0;
      end_heading   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START) begin
        start_heading <= cfg_data;
      end else begin
        end_heading <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      points_seen <= PS_NONE;
      m_tvalid    <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
      older_x     <= '0;
      older_y     <= '0;
      older_heading <= '0;
    end else begin
      m_tvalid <= emit_now || (m_tvalid && !m_tready);
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            px    <= s_tdata[31:0];
            py    <= s_tdata[63:32];
            lastp <= s_tlast;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          if (points_seen != PS_NONE) begin
            state <= S_CORD;
          end else if (!lastp) begin
            prev_x      <= px;
            prev_y      <= py;
            points_seen <= PS_ONE;
            state       <= S_IDLE;
          end else if (out_free) begin
            m_tdata  <= '0;
            m_tuser  <= 1'b1;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_CORD: begin
          if (cord_done) begin
            h     <= cord_heading;
            state <= S_C1;
          end
        end
        S_C1: begin
          emit2 <= 1'b0;
          state <= S_CURV1;
        end
        S_C2: begin
          emit2 <= 1'b1;
          state <= S_CURV2;
        end
        S_CURV1, S_CURV2: begin
          if (curv_done) begin
            state <= S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (out_free) begin
            m_tdata  <= {curv_res.curvature, h};
            m_tuser  <= curv_res.invalid;
            m_tlast  <= emit2;
            if (emit2) begin
              points_seen <= PS_NONE;
              state       <= S_IDLE;
            end else if (lastp) begin
              state <= S_C2;
            end else begin
              older_x       <= prev_x;
              older_y       <= prev_y;
              older_heading <= h;
              prev_x        <= px;
              prev_y        <= py;
              points_seen   <= PS_MORE;
              state         <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PHC_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
  `PHC_ASSERT(a_points_code, points_seen != 2'd3, "bad point count")
  `PHC_ASSERT(a_heading_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 && $signed(m_tdata[15:0]) >= -16'sd25736), "heading out of range")

endmodule
`default_nettype wire

// ===== rtl/phc_cordic.sv =====
`default_nettype none
module phc_cordic
  import phc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] dx,
  input  wire logic signed [32:0] dy,
  output logic                    done,
  output logic signed [15:0]      heading
);

  logic signed [35:0] x;
  logic signed [35:0] y;
  logic signed [16:0] z;
  logic [3:0]         cnt;
  logic               busy;
  logic               zero_vec;
  logic signed [35:0] dx_w;
  logic signed [35:0] dy_w;
  logic signed [35:0] xs;
  logic signed [35:0] ys;

  assign dx_w = {{3{dx[32]}}, dx};
  assign dy_w = {{3{dy[32]}}, dy};
  assign xs   = x >>> cnt;
  assign ys   = y >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      done     <= 1'b0;
      busy     <= 1'b1;
      cnt      <= '0;
      zero_vec <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        if (dy >= 0) begin
          x <= dy_w;
          y <= -dx_w;
          z <= 17'(HALF_PI_Q);
        end else begin
          x <= -dy_w;
          y <= dx_w;
          z <= -17'(HALF_PI_Q);
        end
      end else begin
        x <= dx_w;
        y <= dy_w;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_q(cnt);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_q(cnt);
      end
      done <= (cnt == 4'(CORDIC_STEPS - 1));
      if (cnt == 4'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 4'd1;
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    if (zero_vec) begin
      heading = '0;
    end else if (z > 17'(PI_Q)) begin
      heading = 16'(PI_Q);
    end else if (z < -17'(PI_Q)) begin
      heading = -16'(PI_Q);
    end else begin
      heading = z[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/phc_curv.sv =====
`default_nettype none
module phc_curv
  import phc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [15:0] dh,
  input  wire logic signed [32:0] dx,
  input  wire logic signed [32:0] dy,
  output logic                    done,
  output curv_res_t               res
);

  typedef enum logic [2:0] {S_IDLE, S_SQX, S_SQY, S_SUM, S_SQRT, S_DIV, S_FIN} state_t;

  state_t             state;
  logic [32:0]        ax;
  logic [32:0]        ay;
  logic [30:0]        a;
  logic [30:0]        b;
  logic [30:0]        mop;
  logic [63:0]        p;
  logic [63:0]        q;
  logic [63:0]        root;
  logic [63:0]        bitv;
  logic [63:0]        trial;
  logic [4:0]         cnt;
  logic [30:0]        num;
  logic [32:0]        rem;
  logic [32:0]        rem2;
  logic [31:0]        quo;
  logic               neg;
  logic               short_span;
  logic signed [31:0] quo_s;

  assign ax         = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay         = dy[32] ? 33'(-dy) : 33'(dy);
  assign short_span = (ax == '0 && ay == '0) || ax[32:31] != '0 || ay[32:31] != '0;
  assign mop        = (state == S_SQX) ? a : b;
  assign trial      = root + bitv;
  assign rem2       = {rem[31:0], num[30]};

  always_comb begin
    quo_s = neg ? -$signed(quo) : $signed(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= ((state == S_IDLE) && start && short_span) || (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            a   <= ax[30:0];
            b   <= ay[30:0];
            neg <= dh[15];
            num <= {dh[15] ? 15'(-dh) : dh[14:0], 16'd0} >> 2;
            if (ax == '0 && ay == '0) begin
              res <= '{curvature: '0, invalid: 1'b1};
            end else if (ax[32:31] != '0 || ay[32:31] != '0) begin
              res <= '{curvature: '0, invalid: 1'b0};
            end else begin
              state <= S_SQX;
            end
          end
        end
        S_SQX: begin
          p     <= mop * mop;
          state <= S_SQY;
        end
        S_SQY: begin
          q     <= p;
          p     <= mop * mop;
          state <= S_SUM;
        end
        S_SUM: begin
          q     <= q + p;
          root  <= '0;
          bitv  <= 64'd1 << 62;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (q >= trial) begin
            q    <= q - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            rem   <= '0;
            quo   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, root[31:0]}) begin
            rem <= rem2 - {1'b0, root[31:0]};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[30:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res   <= '{curvature: quo_s, invalid: 1'b0};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import phc_pkg::*;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [31:0] curvature;
    logic               invalid;
    logic               last_result;
  } geom_t;

  localparam int HDG_MAX = 25736;
  localparam int HDG_MIN = -25736;
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  geom_t expected_q[$];
  int error_count = 0;
  bit sink_enable = 1'b0;

  logic signed [15:0] start_hdg, end_hdg;
  longint pt_prev_x, pt_prev_y, pt_older_x, pt_older_y;
  int pt_older_hdg;
  int pt_count;

  polyline_heading_curvature u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic int cordic_heading(longint x, longint y);
    int z;
    longint t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += int'(atan_q(4'(i)));
      end else begin
        x = x - ys; y = y + xs; z -= int'(atan_q(4'(i)));
      end
    end
    if (z > HDG_MAX) z = HDG_MAX;
    if (z < HDG_MIN) z = HDG_MIN;
    return z;
  endfunction

  function automatic int wrap_turn(int d);
    while (d > PI_Q) d -= TWO_PI_Q;
    while (d <= -PI_Q) d += TWO_PI_Q;
    return d;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned q);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > q) b >>= 2;
    while (b != 0) begin
      if (q >= res + b) begin
        q -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic geom_t bend_result(int h, int dh, longint dx, longint dy, bit lst);
    geom_t r;
    longint ax, ay, c;
    longint unsigned len;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    r.heading = 16'(h);
    r.last_result = lst;
    r.invalid = 1'b0;
    c = 0;
    if (ax == 0 && ay == 0) begin
      r.invalid = 1'b1;
    end else if (ax < 64'sd2147483648 && ay < 64'sd2147483648) begin
      len = root_floor(longint'(ax * ax) + longint'(ay * ay));
      c = (longint'(dh) * 16384) / longint'(len);
      if (c > 64'sd2147483647) c = 64'sd2147483647;
      if (c < -64'sd2147483648) c = -64'sd2147483648;
    end
    r.curvature = 32'(c);
    return r;
  endfunction

  task automatic expect_result(geom_t r);
    expected_q = {expected_q, r};
  endtask

  task automatic predict_point(logic signed [31:0] x, logic signed [31:0] y, bit lst);
    longint px, py;
    int h;
    px = x;
    py = y;
    if (pt_count == 0) begin
      if (lst) begin
        expect_result('{16'sd0, 32'sd0, 1'b1, 1'b1});
      end else begin
        pt_prev_x = px; pt_prev_y = py; pt_count = 1;
      end
      return;
    end
    h = cordic_heading(px - pt_prev_x, py - pt_prev_y);
    if (pt_count == 1)
      expect_result(bend_result(h, wrap_turn(h - start_hdg),
                                px - pt_prev_x, py - pt_prev_y, 1'b0));
    else
      expect_result(bend_result(h, wrap_turn(h - pt_older_hdg),
                                px - pt_older_x, py - pt_older_y, 1'b0));
    if (lst) begin
      expect_result(bend_result(h, wrap_turn(end_hdg - h),
                                px - pt_prev_x, py - pt_prev_y, 1'b1));
      pt_count = 0;
      return;
    end
    pt_older_x = pt_prev_x; pt_older_y = pt_prev_y; pt_older_hdg = h;
    pt_prev_x = px; pt_prev_y = py; pt_count = 2;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit lst);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    predict_point(x, y, lst);
  endtask

  task automatic drain();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    while (n < 400) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic write_reg(logic idx, logic signed [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_START) start_hdg = val; else end_hdg = val;
  endtask

  always @(posedge clk) begin
    geom_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[47:16], m_tuser, m_tlast};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got.heading, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.heading !== want.heading)
          report_mismatch("heading", got.heading, want.heading);
        if (got.curvature !== want.curvature)
          report_mismatch("curvature", got.curvature, want.curvature);
        if (got.invalid !== want.invalid)
          report_mismatch("invalid", got.invalid, want.invalid);
        if (got.last_result !== want.last_result)
          report_mismatch("last_result", got.last_result, want.last_result);
      end
    end
  end

  initial begin
    int wait_cycles;
    wait (sink_enable);
    forever begin
      wait_cycles = $urandom_range(0, 7);
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic test_corner_cases();
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sd1000, 32'sd0, 1'b0);
    send_point(32'sd1000, 32'sd0, 1'b1);
    send_point(32'h7FFFFFFF, 32'h80000000, 1'b0);
    send_point(32'h80000000, 32'h7FFFFFFF, 1'b0);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
    send_point(-32'sd5, 32'sd0, 1'b0);
    send_point(-32'sd10, 32'sd0, 1'b0);
    send_point(-32'sd10, -32'sd7, 1'b0);
    send_point(-32'sd10, 32'sd9, 1'b0);
    send_point(32'sd3, 32'sd2, 1'b1);
    send_point(32'sd100, 32'sd100, 1'b0);
    send_point(32'sd101, 32'sd100, 1'b1);
    send_point(32'h80000000, 32'h80000000, 1'b0);
    send_point(32'h80000000, 32'h80000001, 1'b1);
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_START, 16'(HDG_MAX));
    write_reg(CFG_END, 16'(HDG_MIN));
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(-32'sd50, 32'sd1, 1'b0);
    send_point(-32'sd90, -32'sd3, 1'b1);
    write_reg(CFG_START, 16'(HDG_MIN));
    write_reg(CFG_END, 16'(HDG_MAX));
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(-32'sd50, -32'sd1, 1'b0);
    send_point(32'sd10, 32'sd0, 1'b1);
  endtask

  task automatic test_random_runs(int count);
    int sent, len, rng;
    logic signed [31:0] x, y;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 10);
      rng = $urandom_range(0, 3);
      x = $urandom;
      y = $urandom;
      for (int i = 0; i < len; i++) begin
        case (rng)
          0: begin x = x + $signed(5'($urandom)); y = y + $signed(5'($urandom)); end
          1: begin x = x + $signed(16'($urandom)); y = y + $signed(16'($urandom)); end
          2: begin x = $urandom; y = $urandom; end
          default: begin
            x = x + $signed(12'($urandom));
            if ($urandom_range(0, 3) != 0) y = y + $signed(12'($urandom));
          end
        endcase
        send_point(x, y, i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 40) == 0) drain();
      if ($urandom_range(0, 150) == 0)
        write_reg($urandom_range(0, 1) ? CFG_END : CFG_START,
                  16'($urandom_range(0, 2 * HDG_MAX) - HDG_MAX));
    end
  endtask

  initial begin
    start_hdg = 0;
    end_hdg = 0;
    pt_count = 0;
    pt_prev_x = 0; pt_prev_y = 0; pt_older_x = 0; pt_older_y = 0; pt_older_hdg = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    sink_enable <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_config_extremes();
    write_reg(CFG_START, 16'sd0);
    write_reg(CFG_END, 16'sd0);
    test_random_runs(900);
    drain();
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
